// ----- hdl/lsra_pkg.sv -----
// shared constants, types and control structs for the linear scan allocator
`default_nettype none
package lsra_pkg;

  localparam int NUM_REGS = 7;
  localparam int POS_BITS = 16;
  localparam int ID_BITS  = 16;
  localparam int AGE_BITS = 16;
  localparam int PHYS_W   = 3;
  localparam int CFG_W    = 3;
  localparam int RIDX_W   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  localparam logic [CFG_W-1:0] USABLE_RESET = CFG_W'(7);

  localparam logic KIND_CLEAR    = 1'b0;
  localparam logic KIND_INTERVAL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_SCAN,
    ST_PLACE,
    ST_FINISH
  } lsra_state_t;

  typedef struct packed {
    logic load;      // latch the accepted request
    logic expire;    // free ended intervals, try a free register or clear
    logic scan;      // one step of the eviction search
    logic evict;     // place over the chosen victim
    logic out_load;  // move the result to the output register
  } lsra_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic found;
    logic scan_last;
    logic out_free;
  } lsra_sts_t;

endpackage
`default_nettype wire

// ----- hdl/lsra_ctrl.sv -----
// controller state machine sequencing one request at a time
`default_nettype none
module lsra_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lsra_pkg::lsra_sts_t sts,
  output lsra_pkg::lsra_cmd_t      cmd
);
  import lsra_pkg::*;

  lsra_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXPIRE;
      end
      ST_EXPIRE: begin
        if (sts.is_clear || sts.found) state_nxt = ST_FINISH;
        else                           state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_PLACE;
      end
      ST_PLACE: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EXPIRE: cmd.expire = 1'b1;
      ST_SCAN:   cmd.scan   = 1'b1;
      ST_PLACE:  cmd.evict  = 1'b1;
      ST_FINISH: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/lsra_dp.sv -----
// datapath: register file state, free search, victim scan and result registers
`default_nettype none
module lsra_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lsra_pkg::lsra_cmd_t          cmd,
  output lsra_pkg::lsra_sts_t               sts,
  input  wire logic                         in_kind,
  input  wire logic [15:0]                  in_virt_id,
  input  wire logic [15:0]                  in_start_pos,
  input  wire logic [15:0]                  in_end_pos,
  input  wire logic                         cfg_valid,
  input  wire logic [lsra_pkg::CFG_W-1:0]   cfg_usable_regs,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic [15:0]                       out_owner_id,
  output logic                              out_got_register,
  output logic [lsra_pkg::PHYS_W-1:0]       out_phys_reg,
  output logic                              out_victim_valid,
  output logic [15:0]                       out_victim_id
);
  import lsra_pkg::*;

  // allocation state
  logic [NUM_REGS-1:0] busy_r, busy_nxt;
  logic [POS_BITS-1:0] end_r   [NUM_REGS];
  logic [ID_BITS-1:0]  owner_r [NUM_REGS];
  logic [AGE_BITS-1:0] age_r   [NUM_REGS];
  logic [AGE_BITS-1:0] age_ctr_r, age_ctr_nxt;
  logic [CFG_W-1:0]    usable_r;

  // current request
  logic                item_kind_r;
  logic [ID_BITS-1:0]  item_id_r;
  logic [POS_BITS-1:0] item_start_r;
  logic [POS_BITS-1:0] item_end_r;

  // victim search
  logic [RIDX_W-1:0]   scan_idx_r;
  logic [POS_BITS-1:0] best_end_r;
  logic [AGE_BITS-1:0] best_age_r;
  logic                vic_valid_r;
  logic [RIDX_W-1:0]   vic_idx_r;

  // result before the output stage
  logic                res_got_r;
  logic [PHYS_W-1:0]   res_phys_r;
  logic                res_vv_r;
  logic [ID_BITS-1:0]  res_vid_r;

  logic                out_valid_r;

  logic [NUM_REGS-1:0] busy_live;
  logic                found;
  logic [RIDX_W-1:0]   found_idx;
  logic [POS_BITS-1:0] cur_end;
  logic [AGE_BITS-1:0] cur_age;
  logic                better;
  logic                place_en;
  logic [RIDX_W-1:0]   place_idx;
  logic                is_clear;

  assign is_clear = (item_kind_r == KIND_CLEAR);

  // free everything that ended before the new start
  always_comb begin
    for (int r = 0; r < NUM_REGS; r++) begin
      busy_live[r] = busy_r[r] && !(end_r[r] < item_start_r);
    end
  end

  // lowest free register under the usable limit
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int r = 0; r < NUM_REGS; r++) begin
      if (!found && !busy_live[r] && (r < int'(usable_r))) begin
        found     = 1'b1;
        found_idx = RIDX_W'(r);
      end
    end
  end

  // largest end beyond the new end, oldest on ties
  assign cur_end = end_r[scan_idx_r];
  assign cur_age = age_ctr_r - age_r[scan_idx_r];
  assign better  = busy_r[scan_idx_r] &&
                   ((cur_end > best_end_r) ||
                    (vic_valid_r && (cur_end == best_end_r) && (cur_age > best_age_r)));

  always_comb begin
    place_en  = 1'b0;
    place_idx = found_idx;
    if (cmd.expire && !is_clear && found) begin
      place_en = 1'b1;
    end else if (cmd.evict && vic_valid_r) begin
      place_en  = 1'b1;
      place_idx = vic_idx_r;
    end
  end

  always_comb begin
    busy_nxt    = busy_r;
    age_ctr_nxt = age_ctr_r;
    if (cmd.expire && is_clear) begin
      busy_nxt    = '0;
      age_ctr_nxt = '0;
    end else begin
      if (cmd.expire) busy_nxt = busy_live;
      if (place_en) begin
        busy_nxt[place_idx] = 1'b1;
        age_ctr_nxt         = age_ctr_r + AGE_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= '0;
      age_ctr_r   <= '0;
      usable_r    <= USABLE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      age_ctr_r <= age_ctr_nxt;
      if (cfg_valid) usable_r <= cfg_usable_regs;
      if (cmd.out_load)   out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (place_en) begin
      end_r[place_idx]   <= item_end_r;
      owner_r[place_idx] <= item_id_r;
      age_r[place_idx]   <= age_ctr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_kind_r  <= in_kind;
      item_id_r    <= in_virt_id;
      item_start_r <= POS_BITS'(in_start_pos);
      item_end_r   <= POS_BITS'(in_end_pos);
    end
    if (cmd.expire) begin
      res_got_r   <= !is_clear && found;
      res_phys_r  <= (!is_clear && found) ? PHYS_W'(found_idx) : '0;
      res_vv_r    <= 1'b0;
      res_vid_r   <= '0;
      scan_idx_r  <= '0;
      best_end_r  <= item_end_r;
      best_age_r  <= '0;
      vic_valid_r <= 1'b0;
      vic_idx_r   <= '0;
    end
    if (cmd.scan) begin
      scan_idx_r <= scan_idx_r + RIDX_W'(1);
      if (better) begin
        best_end_r  <= cur_end;
        best_age_r  <= cur_age;
        vic_valid_r <= 1'b1;
        vic_idx_r   <= scan_idx_r;
      end
    end
    if (cmd.evict && vic_valid_r) begin
      res_got_r  <= 1'b1;
      res_phys_r <= PHYS_W'(vic_idx_r);
      res_vv_r   <= 1'b1;
      res_vid_r  <= owner_r[vic_idx_r];
    end
    if (cmd.out_load) begin
      out_owner_id     <= item_id_r;
      out_got_register <= res_got_r;
      out_phys_reg     <= res_phys_r;
      out_victim_valid <= res_vv_r;
      out_victim_id    <= res_vid_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.is_clear  = is_clear;
  assign sts.found     = found;
  assign sts.scan_last = (scan_idx_r == RIDX_W'(NUM_REGS - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule
`default_nettype wire

// ----- hdl/linear_scan_register_allocator.sv -----
// linear scan allocator: after a request is accepted, the expire step frees ended
// intervals and takes a free register or handles a clear; if none is free, the
// victim scan visits each physical register, then a placement step runs
// one request in flight; a finished result may wait in the output register
// while the next request is taken; the register file scan and output stalls set the rate
// synchronous active-low reset clears busy bits, age counter and handshakes;
// usable register count resets to 7
`default_nettype none
module linear_scan_register_allocator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_kind,
  input  wire logic [15:0]                in_virt_id,
  input  wire logic [15:0]                in_start_pos,
  input  wire logic [15:0]                in_end_pos,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [15:0]                     out_owner_id,
  output logic                            out_got_register,
  output logic [lsra_pkg::PHYS_W-1:0]     out_phys_reg,
  output logic                            out_victim_valid,
  output logic [15:0]                     out_victim_id,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [lsra_pkg::CFG_W-1:0] cfg_usable_regs
);
  import lsra_pkg::*;

  lsra_cmd_t cmd;
  lsra_sts_t sts;

  assign cfg_ready = 1'b1;

  lsra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsra_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_kind),
    .in_virt_id       (in_virt_id),
    .in_start_pos     (in_start_pos),
    .in_end_pos       (in_end_pos),
    .cfg_valid        (cfg_valid),
    .cfg_usable_regs  (cfg_usable_regs),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_owner_id     (out_owner_id),
    .out_got_register (out_got_register),
    .out_phys_reg     (out_phys_reg),
    .out_victim_valid (out_victim_valid),
    .out_victim_id    (out_victim_id)
  );

endmodule
`default_nettype wire

// ----- bench/linear_scan_register_allocator_tb.sv -----
// testbench for the linear scan register allocator: directed, age-tie and random functions checked by a scoreboard
`timescale 1ns / 1ps

typedef struct packed {
  logic [15:0]                 owner_id;
  logic                        got_register;
  logic [lsra_pkg::PHYS_W-1:0] phys_reg;
  logic                        victim_valid;
  logic [15:0]                 victim_id;
} alloc_result_t;

class alloc_scoreboard;
  logic [lsra_pkg::CFG_W-1:0] usable;
  bit          busy   [lsra_pkg::NUM_REGS];
  logic [15:0] end_at [lsra_pkg::NUM_REGS];
  logic [15:0] owner  [lsra_pkg::NUM_REGS];
  logic [15:0] stamp  [lsra_pkg::NUM_REGS];
  logic [15:0] age_ctr;
  alloc_result_t expected_grants [$];
  int requests = 0;
  int placements = 0;
  int evictions = 0;
  int spills = 0;
  int mismatches = 0;

  function new();
    usable = lsra_pkg::USABLE_RESET;
    foreach (busy[r]) busy[r] = 1'b0;
    age_ctr = '0;
  endfunction

  function void set_usable(logic [lsra_pkg::CFG_W-1:0] value);
    usable = value;
  endfunction

  function int pending();
    return expected_grants.size();
  endfunction

  // works out the grant for one accepted request
  function void note_request(logic kind, logic [15:0] id, logic [15:0] first,
                             logic [15:0] last);
    alloc_result_t g;
    int lim;
    int slot;
    int victim;
    logic [15:0] best_end;
    logic [15:0] best_age;
    logic [15:0] age;
    g = '0;
    g.owner_id = id;
    slot = -1;
    victim = -1;
    requests++;
    if (kind == lsra_pkg::KIND_CLEAR) begin
      foreach (busy[r]) busy[r] = 1'b0;
      age_ctr = '0;
    end else begin
      lim = (usable > lsra_pkg::NUM_REGS) ? lsra_pkg::NUM_REGS : int'(usable);
      for (int r = 0; r < lsra_pkg::NUM_REGS; r++)
        if (busy[r] && end_at[r] < first) busy[r] = 1'b0;
      for (int r = 0; r < lim && slot < 0; r++)
        if (!busy[r]) slot = r;
      if (slot < 0) begin
        // eviction candidate must end strictly after the new interval
        best_end = last;
        best_age = '0;
        for (int r = 0; r < lsra_pkg::NUM_REGS; r++) begin
          if (busy[r]) begin
            age = age_ctr - stamp[r];
            if (end_at[r] > best_end ||
                (victim >= 0 && end_at[r] == best_end && age > best_age)) begin
              best_end = end_at[r];
              best_age = age;
              victim = r;
            end
          end
        end
        if (victim >= 0) begin
          g.victim_valid = 1'b1;
          g.victim_id = owner[victim];
          slot = victim;
          evictions++;
        end
      end
      if (slot >= 0) begin
        busy[slot] = 1'b1;
        owner[slot] = id;
        end_at[slot] = last;
        stamp[slot] = age_ctr;
        age_ctr = age_ctr + 16'd1;
        g.got_register = 1'b1;
        g.phys_reg = lsra_pkg::PHYS_W'(slot);
        placements++;
      end else begin
        spills++;
      end
    end
    expected_grants.insert(expected_grants.size(), g);
  endfunction

  function void check_result(alloc_result_t seen);
    alloc_result_t want;
    if (expected_grants.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected grant: owner %h with nothing pending", seen.owner_id);
      return;
    end
    want = expected_grants.pop_front();
    if (seen.owner_id !== want.owner_id || seen.got_register !== want.got_register ||
        seen.phys_reg !== want.phys_reg || seen.victim_valid !== want.victim_valid ||
        seen.victim_id !== want.victim_id) begin
      mismatches++;
      if (mismatches <= 10) begin
        $write("grant mismatch: expected owner %h got %b reg %0d victim %b/%h, ",
               want.owner_id, want.got_register, want.phys_reg, want.victim_valid,
               want.victim_id);
        $display("actual owner %h got %b reg %0d victim %b/%h",
                 seen.owner_id, seen.got_register, seen.phys_reg,
                 seen.victim_valid, seen.victim_id);
      end
    end
  endfunction
endclass

module linear_scan_register_allocator_tb;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int SWEEP_LEN = 24;
  localparam logic [29:0] PHASE_LIMITS = {3'd7, 3'd2, 3'd7, 3'd4, 3'd6,
                                          3'd2, 3'd5, 3'd0, 3'd1, 3'd3};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [15:0] in_virt_id = '0;
  logic [15:0] in_start_pos = '0;
  logic [15:0] in_end_pos = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_owner_id;
  logic out_got_register;
  logic [lsra_pkg::PHYS_W-1:0] out_phys_reg;
  logic out_victim_valid;
  logic [15:0] out_victim_id;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lsra_pkg::CFG_W-1:0] cfg_usable_regs = '0;

  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int hold_len = 0;
  int stall_cycles = 0;
  alloc_scoreboard sb;
  alloc_result_t seen;

  linear_scan_register_allocator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_virt_id       (in_virt_id),
    .in_start_pos     (in_start_pos),
    .in_end_pos       (in_end_pos),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_owner_id     (out_owner_id),
    .out_got_register (out_got_register),
    .out_phys_reg     (out_phys_reg),
    .out_victim_valid (out_victim_valid),
    .out_victim_id    (out_victim_id),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_usable_regs  (cfg_usable_regs)
  );

  always #5 clk = ~clk;

  task automatic send_request(input logic kind, input logic [15:0] id,
                              input logic [15:0] first, input logic [15:0] last);
    int gap;
    gap = send_idle ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_virt_id <= id;
    in_start_pos <= first;
    in_end_pos <= last;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.note_request(kind, id, first, last);
  endtask

  task automatic interval(input logic [15:0] id, input logic [15:0] first,
                          input logic [15:0] last);
    send_request(lsra_pkg::KIND_INTERVAL, id, first, last);
  endtask

  // stop offering and let every pending grant come back
  task automatic await_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_usable(input logic [lsra_pkg::CFG_W-1:0] value);
    await_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_usable_regs <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    sb.set_usable(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    send_request(lsra_pkg::KIND_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    interval(16'h0000, 16'd0, 16'd50);
    interval(16'd1, 16'd0, 16'd60);
    interval(16'd2, 16'd1, 16'd60);
    interval(16'd3, 16'd1, 16'd70);
    interval(16'd4, 16'd2, 16'd80);
    interval(16'd5, 16'd2, 16'd80);
    interval(16'd6, 16'd3, 16'hFFFF);
    interval(16'hFFFF, 16'd4, 16'd10);   // evicts the longest interval
    interval(16'd8, 16'd5, 16'd60);      // tie on end, older one goes
    interval(16'd9, 16'd6, 16'd100);     // nothing ends later, spills itself
    interval(16'd10, 16'd12, 16'd3);     // end before start
    interval(16'd11, 16'hFFFF, 16'hFFFF);
    send_request(lsra_pkg::KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    write_usable(3'd0);
    interval(16'd12, 16'd0, 16'd0);
    interval(16'd13, 16'd1, 16'hFFFF);
    write_usable(3'd1);
    interval(16'd14, 16'd0, 16'd5);
    interval(16'd15, 16'd1, 16'd3);
    interval(16'd16, 16'd2, 16'd9);
    send_request(lsra_pkg::KIND_CLEAR, 16'h5A5A, 16'hA5A5, 16'h5A5A);
    write_usable(3'd7);
    interval(16'd17, 16'd10, 16'd100);
    interval(16'd18, 16'd10, 16'd200);
    interval(16'd19, 16'd10, 16'd300);
    // limit lowered with registers above it still busy
    write_usable(3'd1);
    interval(16'd20, 16'd11, 16'd50);
    interval(16'd21, 16'd150, 16'd160);
  endtask

  // repeated placements in one register while the others stay busy, then age ties
  task automatic run_age_ties();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_request(lsra_pkg::KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    write_usable(3'd7);
    interval(16'h0100, 16'd0, 16'd0);
    for (int r = 1; r < lsra_pkg::NUM_REGS; r++)
      interval(16'(16'h0100 + r), 16'd0, 16'hFFFF);
    write_usable(3'd1);
    for (int k = 1; k <= SWEEP_LEN; k++)
      interval(16'(k), 16'(k), 16'(k));
    for (int k = 0; k < 3; k++)
      interval(16'(16'h0200 + k), 16'd65534, 16'd65534);
    send_request(lsra_pkg::KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic random_functions(input int n_items);
    int sent;
    int n;
    int pos;
    int last;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 7) != 0) begin
        send_request(lsra_pkg::KIND_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end
      n = $urandom_range(3, 40);
      pos = ($urandom_range(0, 5) == 0) ? int'($urandom_range(65400, 65535))
                                         : int'($urandom_range(0, 65000));
      for (int i = 0; i < n && sent < n_items; i++) begin
        if ($urandom_range(0, 11) == 0) begin
          send_request(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
          pos = pos + int'($urandom_range(0, 3));
          if (pos > 65535) pos = 65535;
          case ($urandom_range(0, 9))
            0: last = pos - int'($urandom_range(0, 40));
            1: last = 65535;
            2: last = pos + int'($urandom_range(0, 65535));
            default: last = pos + int'($urandom_range(0, 24));
          endcase
          if (last < 0) last = 0;
          if (last > 65535) last = 65535;
          send_request(lsra_pkg::KIND_INTERVAL, 16'($urandom), 16'(pos), 16'(last));
        end
        sent++;
      end
    end
  endtask

  initial begin : receiver
    int wait_n;
    forever begin
      if (hold_len > 0) begin
        // long hold-off so the block backs up into its input
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      wait_n = recv_idle ? $urandom_range(0, 19) : 0;
      if (wait_n > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (wait_n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      seen.owner_id = out_owner_id;
      seen.got_register = out_got_register;
      seen.phys_reg = out_phys_reg;
      seen.victim_valid = out_victim_valid;
      seen.victim_id = out_victim_id;
      sb.check_result(seen);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
        (cfg_valid && cfg_ready === 1'b1))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[linear_scan_register_allocator] ERROR");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_age_ties();
    for (int p = 0; p < 10; p++) begin
      send_idle = (p % 3) != 1;
      recv_idle = (p % 4) != 2;
      write_usable(PHASE_LIMITS[3*p +: 3]);
      if (p == 1) hold_len = 300;
      random_functions(150);
    end
    await_idle();
    $display("covered %0d requests: %0d placed, %0d by eviction, %0d spilled",
             sb.requests, sb.placements, sb.evictions, sb.spills);
    $display("usable limits 0 through 7, age ties, long output stall; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("[linear_scan_register_allocator] OK");
    else
      $display("[linear_scan_register_allocator] ERROR");
    $finish;
  end
endmodule
